/* design/dltq_pkg.sv */
// Package with shared types and constants of the delta list timer queue.
`default_nettype none
package dltq_pkg;
    localparam int MAX_TIMERS = 16;
    localparam int SLOT_W = $clog2(MAX_TIMERS);
    localparam int LINK_W = SLOT_W + 1;
    localparam logic [LINK_W-1:0] NIL_LINK = LINK_W'(MAX_TIMERS);

    localparam logic [1:0] REQ_TICK    = 2'd0;
    localparam logic [1:0] REQ_START   = 2'd1;
    localparam logic [1:0] REQ_STOP    = 2'd2;
    localparam logic [1:0] REQ_SERVICE = 2'd3;

    localparam logic [2:0] RESP_TICKED  = 3'd0;
    localparam logic [2:0] RESP_STARTED = 3'd1;
    localparam logic [2:0] RESP_FULL    = 3'd2;
    localparam logic [2:0] RESP_EXPIRED = 3'd3;
    localparam logic [2:0] RESP_STOPPED = 3'd4;
    localparam logic [2:0] RESP_BAD     = 3'd5;
    localparam logic [2:0] RESP_NONE    = 3'd6;

    typedef struct packed {
        logic [2:0]  kind;
        logic [3:0]  slot;
        logic [15:0] tag;
        logic        last;
    } resp_t;
endpackage
`default_nettype wire

/* design/delta_list_timer_queue.sv */
// Top level of the delta list timer queue: sequencer, entry registers and one subtractor.
//
// The block keeps up to MAX_TIMERS timers in a delta-sorted linked list.
// Input transactions (s_valid/s_ready) carry a request: tick, start, stop or
// service. Result transactions (m_valid/m_ready) carry resp_kind, timer_slot,
// tag_out, uptime_ticks and last; last marks the final result of a request.
// A service request gives one result per expired timer (at most sixteen), or a
// single "nothing expired" result. Every other request gives one result.
// Only one request is in work at a time; s_ready is low while it runs and
// comes back the cycle after the final result transaction is taken.
// A stop or a start into a full pool presents its result in the cycle after it
// is accepted. A tick walks past the zero-delta entries one list step at a
// time. A start walks the list with one compare-and-subtract per cycle.
// A service pops each expired entry, reports it and, for every periodic timer
// it reinserts, makes such a walk.
// The shared 32-bit subtractor gives every walk its pace: one list step a cycle.
// Results sit in an output register; while the receiver stalls, the
// sequencer waits in place and nothing is lost or repeated.
// Reset (aresetn low, synchronous) empties the list, frees every slot and
// clears the uptime count. Entry payloads are not cleared.
`default_nettype none
module delta_list_timer_queue
    import dltq_pkg::*;
(
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         s_valid,
    output logic        s_ready,
    input  wire  [1:0]  s_req_type,
    input  wire  [31:0] s_interval,
    input  wire         s_periodic,
    input  wire  [3:0]  s_slot,
    input  wire  [15:0] s_client_tag,
    output logic        m_valid,
    input  wire         m_ready,
    output logic [2:0]  m_resp_kind,
    output logic [3:0]  m_timer_slot,
    output logic [15:0] m_tag_out,
    output logic [31:0] m_uptime_ticks,
    output logic        m_last
);
    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_TICK = 3'd1;
    localparam logic [2:0] ST_INS  = 3'd2;
    localparam logic [2:0] ST_SERV = 3'd3;
    localparam logic [2:0] ST_OUT  = 3'd4;

    logic [2:0] state_reg;

    logic [31:0] delta_reg [MAX_TIMERS];
    logic [31:0] reload_reg [MAX_TIMERS];
    logic [15:0] tag_reg [MAX_TIMERS];
    logic [LINK_W-1:0] link_reg [MAX_TIMERS];
    logic [MAX_TIMERS-1:0] busy_reg, stopped_reg;
    logic [LINK_W-1:0] head_reg;
    logic [31:0] uptime_reg;

    // Walk registers shared by tick and insert.
    logic [LINK_W-1:0] cur_reg, prev_reg;
    logic [SLOT_W-1:0] ent_reg;
    logic [31:0] d_reg;
    logic [4:0] guard_reg;   // step count of a walk
    logic [4:0] n_reg;       // expiries reported in this service
    logic [4:0] sguard_reg;  // service pops
    logic serv_reg;          // insert belongs to a service

    resp_t resp_reg;
    logic  mv_reg;

    // Shared subtractor.
    logic [31:0] sub_a, sub_b, sub_y;
    assign sub_y = sub_a - sub_b;

    logic [SLOT_W-1:0] cur_s, head_s;
    assign cur_s  = cur_reg[SLOT_W-1:0];
    assign head_s = head_reg[SLOT_W-1:0];

    logic cur_ok, head_ok;
    assign cur_ok  = cur_reg < NIL_LINK;
    assign head_ok = head_reg < NIL_LINK;

    // Lowest free slot.
    logic              free_any;
    logic [SLOT_W-1:0] free_idx;
    always_comb begin
        free_any = 1'b0;
        free_idx = '0;
        for (int i = MAX_TIMERS - 1; i >= 0; i--) begin
            if (!busy_reg[i]) begin
                free_any = 1'b1;
                free_idx = SLOT_W'(i);
            end
        end
    end

    logic accept;
    assign s_ready = (state_reg == ST_IDLE) && !mv_reg;
    assign accept  = s_valid && s_ready;

    logic stop_bad;
    assign stop_bad = !busy_reg[s_slot[SLOT_W-1:0]] || stopped_reg[s_slot[SLOT_W-1:0]];

    logic walk_done, ins_stop;
    assign walk_done = !cur_ok || (guard_reg == 5'(MAX_TIMERS));
    assign ins_stop  = d_reg < delta_reg[cur_s];

    always_comb begin
        sub_a = d_reg;
        sub_b = delta_reg[cur_s];
        unique case (state_reg)
            ST_TICK: begin
                sub_a = delta_reg[cur_s];
                sub_b = 32'd1;
            end
            ST_INS: begin
                if (ins_stop) begin
                    sub_a = delta_reg[cur_s];
                    sub_b = d_reg;
                end
            end
            ST_IDLE: begin
                // Stop folds delta into successor: a + b as a - (-b).
                sub_a = delta_reg[link_reg[s_slot[SLOT_W-1:0]][SLOT_W-1:0]];
                sub_b = 32'd0 - delta_reg[s_slot[SLOT_W-1:0]];
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            busy_reg    <= '0;
            stopped_reg <= '0;
            head_reg    <= NIL_LINK;
            uptime_reg  <= '0;
            mv_reg      <= 1'b0;
        end else begin
            if (mv_reg && m_ready) mv_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        cur_reg   <= head_reg;
                        prev_reg  <= NIL_LINK;
                        guard_reg <= '0;
                        serv_reg  <= 1'b0;
                        n_reg     <= '0;
                        sguard_reg <= '0;
                        case (s_req_type)
                            REQ_TICK: begin
                                resp_reg   <= '{kind: RESP_TICKED, slot: 4'd0, tag: 16'd0,
                                                last: 1'b1};
                                uptime_reg <= uptime_reg + 32'd1;
                                state_reg  <= ST_TICK;
                            end
                            REQ_START: begin
                                if (!free_any) begin
                                    resp_reg <= '{kind: RESP_FULL, slot: 4'd0, tag: 16'd0,
                                                  last: 1'b1};
                                    mv_reg <= 1'b1;
                                end else begin
                                    busy_reg[free_idx]    <= 1'b1;
                                    stopped_reg[free_idx] <= 1'b0;
                                    reload_reg[free_idx]  <= s_periodic ? s_interval : 32'd0;
                                    tag_reg[free_idx]     <= s_client_tag;
                                    ent_reg <= free_idx;
                                    d_reg   <= s_interval;
                                    resp_reg <= '{kind: RESP_STARTED, slot: 4'(free_idx),
                                                  tag: s_client_tag, last: 1'b1};
                                    state_reg <= ST_INS;
                                end
                            end
                            REQ_STOP: begin
                                if ({1'b0, s_slot} >= 5'(MAX_TIMERS) || stop_bad) begin
                                    resp_reg <= '{kind: RESP_BAD, slot: s_slot,
                                                  tag: 16'd0, last: 1'b1};
                                end else begin
                                    if (link_reg[s_slot[SLOT_W-1:0]] < NIL_LINK)
                                        delta_reg[link_reg[s_slot[SLOT_W-1:0]][SLOT_W-1:0]]
                                            <= sub_y;
                                    delta_reg[s_slot[SLOT_W-1:0]]   <= 32'd0;
                                    reload_reg[s_slot[SLOT_W-1:0]]  <= 32'd0;
                                    stopped_reg[s_slot[SLOT_W-1:0]] <= 1'b1;
                                    resp_reg <= '{kind: RESP_STOPPED, slot: s_slot,
                                                  tag: 16'd0, last: 1'b1};
                                end
                                mv_reg <= 1'b1;
                            end
                            default: begin
                                state_reg <= ST_SERV;
                            end
                        endcase
                    end
                end
                ST_TICK: begin
                    if (walk_done) begin
                        mv_reg    <= 1'b1;
                        state_reg <= ST_IDLE;
                    end else if (delta_reg[cur_s] != 32'd0) begin
                        delta_reg[cur_s] <= sub_y;
                        mv_reg    <= 1'b1;
                        state_reg <= ST_IDLE;
                    end else begin
                        cur_reg   <= link_reg[cur_s];
                        guard_reg <= guard_reg + 5'd1;
                    end
                end
                ST_INS: begin
                    if (walk_done || ins_stop) begin
                        if (!walk_done) delta_reg[cur_s] <= sub_y;
                        delta_reg[ent_reg] <= d_reg;
                        link_reg[ent_reg]  <= cur_ok ? cur_reg : NIL_LINK;
                        if (prev_reg == NIL_LINK) head_reg <= LINK_W'(ent_reg);
                        else link_reg[prev_reg[SLOT_W-1:0]] <= LINK_W'(ent_reg);
                        if (serv_reg) state_reg <= ST_SERV;
                        else begin
                            mv_reg    <= 1'b1;
                            state_reg <= ST_IDLE;
                        end
                    end else begin
                        d_reg     <= sub_y;
                        prev_reg  <= cur_reg;
                        cur_reg   <= link_reg[cur_s];
                        guard_reg <= guard_reg + 5'd1;
                    end
                end
                ST_SERV: begin
                    if (!mv_reg) begin
                        if (sguard_reg == 5'(MAX_TIMERS) || n_reg == 5'd16 || !head_ok
                                || delta_reg[head_s] != 32'd0) begin
                            if (n_reg == 5'd0) begin
                                resp_reg <= '{kind: RESP_NONE, slot: 4'd0,
                                              tag: 16'd0, last: 1'b1};
                                mv_reg <= 1'b1;
                                state_reg <= ST_IDLE;
                            end else begin
                                resp_reg.last <= 1'b1;
                                state_reg <= ST_OUT;
                            end
                        end else if (n_reg != 5'd0 && !resp_reg.last && !mv_reg
                                     && resp_reg.kind == RESP_EXPIRED && serv_reg
                                     && !stopped_reg[head_s]) begin
                            // A pending expiry report goes out only once another
                            // expiry follows; a stopped head is dropped silently.
                            mv_reg   <= 1'b1;
                            serv_reg <= 1'b0;
                        end else begin
                            sguard_reg <= sguard_reg + 5'd1;
                            head_reg   <= (link_reg[head_s] < NIL_LINK) ? link_reg[head_s]
                                                                        : NIL_LINK;
                            if (stopped_reg[head_s]) begin
                                busy_reg[head_s]    <= 1'b0;
                                stopped_reg[head_s] <= 1'b0;
                            end else begin
                                resp_reg <= '{kind: RESP_EXPIRED, slot: 4'(head_s),
                                              tag: tag_reg[head_s], last: 1'b0};
                                n_reg    <= n_reg + 5'd1;
                                serv_reg <= 1'b1;
                                if (reload_reg[head_s] != 32'd0) begin
                                    ent_reg   <= head_s;
                                    d_reg     <= reload_reg[head_s];
                                    cur_reg   <= (link_reg[head_s] < NIL_LINK)
                                                 ? link_reg[head_s] : NIL_LINK;
                                    prev_reg  <= NIL_LINK;
                                    guard_reg <= '0;
                                    state_reg <= ST_INS;
                                end else begin
                                    busy_reg[head_s] <= 1'b0;
                                end
                            end
                        end
                    end
                end
                ST_OUT: begin
                    if (!mv_reg) begin
                        mv_reg    <= 1'b1;
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_valid        = mv_reg;
    assign m_resp_kind    = resp_reg.kind;
    assign m_timer_slot   = resp_reg.slot;
    assign m_tag_out      = resp_reg.tag;
    assign m_uptime_ticks = uptime_reg;
    assign m_last         = resp_reg.last;

    a_ready_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> !m_valid) else $error("ready while result pending");
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_resp_kind)))
        else $error("result changed while stalled");
    a_head: assert property (@(posedge aclk) disable iff (!aresetn)
        head_reg <= NIL_LINK) else $error("bad head link");
endmodule
`default_nettype wire

/* verif/tb_top.sv */
// Self-checking testbench for the delta list timer queue.
`default_nettype none

class timer_scoreboard;
    logic [31:0] delta_q[16];
    logic [31:0] period_q[16];
    logic [15:0] tag_q[16];
    logic [4:0]  link_q[16];
    bit          busy_q[16];
    bit          dead_q[16];
    logic [4:0]  head_q;
    logic [31:0] uptime_q;
    logic [55:0] pending_results[$];
    int          errors;

    function void clear();
        for (int i = 0; i < 16; i++) begin
            busy_q[i] = 0;
            dead_q[i] = 0;
        end
        head_q = 5'd16;
        uptime_q = 0;
        errors = 0;
    endfunction

    function int count_busy();
        int n;
        n = 0;
        for (int i = 0; i < 16; i++) n += busy_q[i];
        return n;
    endfunction

    function void push_result(logic [2:0] k, logic [3:0] s, logic [15:0] t, bit l);
        pending_results.push_back({k, s, t, uptime_q, l});
    endfunction

    function void link_in(logic [4:0] e);
        logic [4:0]  prev;
        logic [4:0]  cur;
        logic [31:0] d;
        prev = 5'd16;
        cur = head_q;
        d = delta_q[e];
        for (int g = 0; g < 16 && cur < 16; g++) begin
            if (d < delta_q[cur]) begin
                delta_q[cur] -= d;
                break;
            end
            d -= delta_q[cur];
            prev = cur;
            cur = link_q[cur];
        end
        if (cur >= 16) cur = 5'd16;
        delta_q[e] = d;
        link_q[e] = cur;
        if (prev == 16) head_q = e;
        else link_q[prev] = e;
    endfunction

    // Updates the timer pool for one accepted request and queues its results.
    function void note_request(logic [1:0] rq, logic [31:0] iv, bit per,
                               logic [3:0] sl, logic [15:0] tg);
        logic [4:0] cur;
        int         e;
        int         n;
        int         lastidx;
        case (rq)
            dltq_pkg::REQ_TICK: begin
                uptime_q++;
                cur = head_q;
                for (int g = 0; g < 16 && cur < 16; g++) begin
                    if (delta_q[cur] != 0) begin
                        delta_q[cur]--;
                        break;
                    end
                    cur = link_q[cur];
                end
                push_result(dltq_pkg::RESP_TICKED, 4'd0, 16'd0, 1'b1);
            end
            dltq_pkg::REQ_START: begin
                for (e = 0; e < 16; e++) if (!busy_q[e]) break;
                if (e >= 16) begin
                    push_result(dltq_pkg::RESP_FULL, 4'd0, 16'd0, 1'b1);
                end else begin
                    busy_q[e] = 1;
                    dead_q[e] = 0;
                    delta_q[e] = iv;
                    period_q[e] = per ? iv : 0;
                    tag_q[e] = tg;
                    link_in(e[4:0]);
                    push_result(dltq_pkg::RESP_STARTED, e[3:0], tg, 1'b1);
                end
            end
            dltq_pkg::REQ_STOP: begin
                if (!busy_q[sl] || dead_q[sl]) begin
                    push_result(dltq_pkg::RESP_BAD, sl, 16'd0, 1'b1);
                end else begin
                    if (link_q[sl] < 16) delta_q[link_q[sl]] += delta_q[sl];
                    delta_q[sl] = 0;
                    period_q[sl] = 0;
                    dead_q[sl] = 1;
                    push_result(dltq_pkg::RESP_STOPPED, sl, 16'd0, 1'b1);
                end
            end
            default: begin
                n = 0;
                for (int g = 0; g < 16 && n < 16; g++) begin
                    cur = head_q;
                    if (cur >= 16 || delta_q[cur] != 0) break;
                    head_q = link_q[cur];
                    if (head_q >= 16) head_q = 5'd16;
                    if (dead_q[cur]) begin
                        busy_q[cur] = 0;
                        dead_q[cur] = 0;
                        continue;
                    end
                    push_result(dltq_pkg::RESP_EXPIRED, cur[3:0], tag_q[cur], 1'b0);
                    n++;
                    if (period_q[cur] != 0) begin
                        delta_q[cur] = period_q[cur];
                        link_in(cur);
                    end else begin
                        busy_q[cur] = 0;
                    end
                end
                if (n == 0) begin
                    push_result(dltq_pkg::RESP_NONE, 4'd0, 16'd0, 1'b1);
                end else begin
                    lastidx = pending_results.size() - 1;
                    pending_results[lastidx][0] = 1'b1;
                end
            end
        endcase
    endfunction

    function void check_result(logic [2:0] k, logic [3:0] s, logic [15:0] t,
                               logic [31:0] u, logic l);
        logic [55:0] x;
        if (pending_results.size() == 0) begin
            $error("unexpected result kind=%0d slot=%0d", k, s);
            errors++;
            return;
        end
        x = pending_results.pop_front();
        if (x[55:53] !== k) begin
            $error("resp_kind expected %0d actual %0d", x[55:53], k); errors++;
        end
        if (x[52:49] !== s) begin
            $error("timer_slot expected %0d actual %0d", x[52:49], s); errors++;
        end
        if (x[48:33] !== t) begin
            $error("tag_out expected %0h actual %0h", x[48:33], t); errors++;
        end
        if (x[32:1] !== u) begin
            $error("uptime_ticks expected %0d actual %0d", x[32:1], u); errors++;
        end
        if (x[0] !== l) begin
            $error("last expected %0d actual %0d", x[0], l); errors++;
        end
    endfunction
endclass

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import dltq_pkg::*;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [1:0]  s_req_type;
    logic [31:0] s_interval;
    logic        s_periodic;
    logic [3:0]  s_slot;
    logic [15:0] s_client_tag;
    logic        m_valid;
    logic        m_ready;
    logic [2:0]  m_resp_kind;
    logic [3:0]  m_timer_slot;
    logic [15:0] m_tag_out;
    logic [31:0] m_uptime_ticks;
    logic        m_last;

    timer_scoreboard board;
    int          quiet_cycles;
    bit          rx_stall_mode;

    delta_list_timer_queue dut (.*);

    // Free-running clock with a 2 ns period.
    initial begin
        aclk = 0;
        forever #1 aclk = ~aclk;
    end

    // The receiver alternates between stretches that accept every result and
    // stretches that stall on a random pattern, so that back pressure lands on
    // every phase of a long service request.
    always @(posedge aclk) begin
        if ($urandom_range(0, 40) == 0) rx_stall_mode <= ~rx_stall_mode;
        m_ready <= rx_stall_mode ? ($urandom_range(0, 2) != 0) : 1'b1;
    end

    // Every result transaction is checked against the oldest expectation. The
    // watchdog counts cycles in which no transaction of either kind happens.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            board.check_result(m_resp_kind, m_timer_slot, m_tag_out, m_uptime_ticks, m_last);
        if ((s_valid && s_ready) || (m_valid && m_ready)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > 20000) begin
            $display("tb: failure");
            $finish;
        end
    end

    // Presents one request and holds it until the transaction completes. The
    // prediction is updated at the accepting edge, before any result of this
    // request can come back.
    task automatic send_request(logic [1:0] rq, logic [31:0] iv, bit per,
                                logic [3:0] sl, logic [15:0] tg);
        s_valid      <= 1;
        s_req_type   <= rq;
        s_interval   <= iv;
        s_periodic   <= per;
        s_slot       <= sl;
        s_client_tag <= tg;
        do @(posedge aclk); while (!s_ready);
        board.note_request(rq, iv, per, sl, tg);
    endtask

    // Inserts a random pause between bursts; within a burst valid stays high.
    task automatic maybe_pause();
        if ($urandom_range(0, 5) == 0) begin
            s_valid <= 0;
            repeat ($urandom_range(1, 12)) @(posedge aclk);
        end
    endtask

    // Picks a stop handle, usually a live one; a free or stopped slot is legal
    // too and must give a bad handle result.
    function automatic logic [3:0] pick_slot();
        logic [3:0] s;
        for (int i = 0; i < 8; i++) begin
            s = 4'($urandom_range(0, 15));
            if (board.busy_q[s] && !board.dead_q[s]) return s;
        end
        return s;
    endfunction

    task automatic random_request();
        int          r;
        logic [31:0] iv;
        r = $urandom_range(0, 99);
        case ($urandom_range(0, 3))
            0: iv = $urandom();
            1: iv = 0;
            default: iv = $urandom_range(0, 6);
        endcase
        if (r < 35)
            send_request(REQ_TICK, $urandom(), 1'($urandom_range(0, 1)), 4'($urandom()),
                         16'($urandom()));
        else if (r < 60 && board.count_busy() < 16)
            send_request(REQ_START, iv, 1'($urandom_range(0, 1)), 4'($urandom()),
                         16'($urandom()));
        else if (r < 63)
            send_request(REQ_START, iv, 1'($urandom_range(0, 1)), 4'($urandom()),
                         16'($urandom()));
        else if (r < 75)
            send_request(REQ_STOP, $urandom(), 1'($urandom_range(0, 1)), pick_slot(),
                         16'($urandom()));
        else
            send_request(REQ_SERVICE, $urandom(), 1'($urandom_range(0, 1)), 4'($urandom()),
                         16'($urandom()));
    endtask

    initial begin
        board = new();
        board.clear();
        quiet_cycles = 0;
        rx_stall_mode = 0;
        m_ready = 0;
        aresetn = 0;
        s_valid = 0;
        s_req_type = REQ_TICK;
        s_interval = 0;
        s_periodic = 0;
        s_slot = 0;
        s_client_tag = 0;
        repeat (9) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // Directed part: empty service, empty tick, a stop of a free slot, zero
        // interval starts (periodic too), extreme intervals and tags, a full
        // pool, a service that reports a long run of expiries, and a double stop.
        send_request(REQ_SERVICE, 32'd0, 1'b0, 4'd0, 16'd0);
        send_request(REQ_TICK, 32'hFFFF_FFFF, 1'b1, 4'hF, 16'hFFFF);
        send_request(REQ_STOP, 32'd0, 1'b0, 4'hF, 16'd0);
        send_request(REQ_START, 32'd0, 1'b1, 4'd0, 16'hFFFF);
        send_request(REQ_START, 32'hFFFF_FFFF, 1'b1, 4'hF, 16'h0000);
        send_request(REQ_START, 32'hFFFF_FFFF, 1'b0, 4'd0, 16'hA5A5);
        send_request(REQ_STOP, 32'd0, 1'b0, 4'd1, 16'd0);
        send_request(REQ_STOP, 32'd0, 1'b0, 4'd1, 16'd0);
        send_request(REQ_START, 32'd2, 1'b1, 4'd0, 16'h5A5A);
        send_request(REQ_TICK, 32'd0, 1'b0, 4'd0, 16'd0);
        for (int i = 0; i < 12; i++) send_request(REQ_START, 32'd0, i[0], 4'd0, 16'(i));
        send_request(REQ_START, 32'd1, 1'b0, 4'd0, 16'h1234);
        send_request(REQ_SERVICE, 32'd0, 1'b0, 4'd0, 16'd0);
        send_request(REQ_TICK, 32'd0, 1'b0, 4'd0, 16'd0);
        send_request(REQ_SERVICE, 32'hFFFF_FFFF, 1'b1, 4'hF, 16'hFFFF);

        // Random part in bursts with random gaps.
        for (int n = 0; n < 195; n++) begin
            random_request();
            maybe_pause();
        end
        s_valid <= 0;

        while (board.pending_results.size() != 0) @(posedge aclk);
        repeat (400) @(posedge aclk);
        if (board.errors == 0 && board.pending_results.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end
endmodule
`default_nettype wire
